>>> design/rtkr_pkg.sv
`timescale 1ns / 1ps

package rtkr_pkg;

    typedef enum logic [1:0] {
        ACT_MARK   = 2'd0,
        ACT_TOGGLE = 2'd1,
        ACT_LIST   = 2'd2,
        ACT_NONE   = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_PASS,
        ST_FINAL
    } state_t;

    localparam logic CFG_ITEM_COUNT = 1'b0;
    localparam logic CFG_LIST_LIMIT = 1'b1;

    localparam logic [6:0] ITEM_COUNT_RESET = 7'd64;
    localparam logic [6:0] LIST_LIMIT_RESET = 7'd16;
    localparam int         MAX_LIST         = 64;

    typedef struct packed {
        logic clear;
        logic capture;
        logic exec;
        logic pass_start;
        logic take;
        logic final_out;
    } rtkr_cmd_t;

    typedef struct packed {
        logic clear_done;
        logic out_free;
        logic pass_done;
        logic best_found;
        logic has_pend;
        logic cap_hit;
        logic cap_zero;
    } rtkr_status_t;

endpackage

>>> design/rtkr_ctrl.sv
`timescale 1ns / 1ps

module rtkr_ctrl
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  rtkr_pkg::action_t     in_action,
    input  rtkr_pkg::rtkr_status_t status,
    output logic                  in_ready,
    output rtkr_pkg::rtkr_cmd_t   cmd
);
    import rtkr_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (status.clear_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    if (in_action == ACT_LIST)
                    begin
                        if (status.cap_zero)
                        begin
                            state_next = ST_FINAL;
                        end
                        else
                        begin
                            cmd.pass_start = 1'b1;
                            state_next     = ST_PASS;
                        end
                    end
                    else
                    begin
                        state_next = ST_EXEC;
                    end
                end
            end
            ST_EXEC:
            begin
                if (status.out_free)
                begin
                    cmd.exec   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_PASS:
            begin
                if (status.pass_done)
                begin
                    if (!status.best_found)
                    begin
                        state_next = ST_FINAL;
                    end
                    else if (status.out_free || !status.has_pend)
                    begin
                        cmd.take = 1'b1;
                        if (status.cap_hit)
                        begin
                            state_next = ST_FINAL;
                        end
                        else
                        begin
                            cmd.pass_start = 1'b1;
                        end
                    end
                end
            end
            ST_FINAL:
            begin
                if (status.out_free)
                begin
                    cmd.final_out = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

endmodule

>>> design/rtkr_datapath.sv
`timescale 1ns / 1ps

module rtkr_datapath
#(
    parameter int TABLE_ENTRIES = 64,
    parameter int STAMP_BITS    = 64
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic                   cfg_addr,
    input  logic [6:0]             cfg_data,
    input  logic [7:0]             in_data,
    input  logic                   out_ready,
    input  rtkr_pkg::rtkr_cmd_t    cmd,
    output logic                   out_valid,
    output logic [7:0]             out_data,
    output logic [1:0]             out_user,
    output logic                   out_last,
    output rtkr_pkg::rtkr_status_t status
);
    import rtkr_pkg::*;

    localparam int IDX_W   = $clog2(TABLE_ENTRIES);
    localparam int CNT_W   = $clog2(TABLE_ENTRIES + 1);
    localparam int NW      = (CNT_W > 7) ? CNT_W : 7;
    localparam int CAP_MAX = (TABLE_ENTRIES < MAX_LIST) ? TABLE_ENTRIES : MAX_LIST;

    logic [STAMP_BITS-1:0] stamp_mem [TABLE_ENTRIES];
    logic                  fav_mem   [TABLE_ENTRIES];

    logic [6:0]            item_count_reg;
    logic [6:0]            list_limit_reg;
    logic [STAMP_BITS-1:0] seq_reg;
    logic [IDX_W-1:0]      clr_reg;
    action_t               action_reg;
    logic [5:0]            idx_reg;

    logic                  scan_active_reg;
    logic [NW-1:0]         scan_reg;
    logic [STAMP_BITS-1:0] rd_stamp_reg;
    logic [IDX_W-1:0]      rd_idx_reg;
    logic                  rd_vld_reg;
    logic [STAMP_BITS-1:0] q_stamp_reg;
    logic [IDX_W-1:0]      q_idx_reg;
    logic                  q_vld_reg;
    logic                  best_found_reg;
    logic [STAMP_BITS-1:0] best_stamp_reg;
    logic [IDX_W-1:0]      best_idx_reg;
    logic                  prev_vld_reg;
    logic [STAMP_BITS-1:0] prev_stamp_reg;
    logic [IDX_W-1:0]      prev_idx_reg;
    logic                  has_pend_reg;
    logic [IDX_W-1:0]      pend_idx_reg;
    logic [6:0]            cnt_reg;
    logic                  fav_rd_reg;

    logic                  out_valid_reg;
    logic [7:0]            out_data_reg;
    logic [1:0]            out_user_reg;
    logic                  out_last_reg;

    logic [NW-1:0]         n_used;
    logic [6:0]            cap;
    logic                  in_range;
    logic                  issue;
    logic                  qual;
    logic [STAMP_BITS-1:0] seq_next;
    logic [IDX_W-1:0]      idx_addr;
    logic [IDX_W-1:0]      fav_raddr;
    logic                  stamp_we;
    logic [IDX_W-1:0]      stamp_waddr;
    logic [STAMP_BITS-1:0] stamp_wdata;
    logic                  fav_we;
    logic [IDX_W-1:0]      fav_waddr;
    logic                  fav_wdata;
    logic                  out_load;
    logic [7:0]            out_data_next;
    logic [1:0]            out_user_next;
    logic                  out_last_next;

    assign n_used = (NW'(item_count_reg) > NW'(TABLE_ENTRIES)) ? NW'(TABLE_ENTRIES)
                                                                : NW'(item_count_reg);
    assign cap = (list_limit_reg > 7'(CAP_MAX)) ? 7'(CAP_MAX) : list_limit_reg;
    assign in_range = NW'(idx_reg) < n_used;
    assign issue = scan_active_reg && (scan_reg < n_used);
    assign seq_next = seq_reg + 1'b1;
    assign idx_addr = IDX_W'(idx_reg);
    assign fav_raddr = cmd.capture ? IDX_W'(in_data[7:2]) : idx_addr;

    assign qual = (rd_stamp_reg != '0)
                  && (!prev_vld_reg
                      || (rd_stamp_reg < prev_stamp_reg)
                      || ((rd_stamp_reg == prev_stamp_reg) && (rd_idx_reg > prev_idx_reg)));

    always_comb
    begin
        stamp_we    = 1'b0;
        stamp_waddr = idx_addr;
        stamp_wdata = seq_next;
        fav_we      = 1'b0;
        fav_waddr   = idx_addr;
        fav_wdata   = ~fav_rd_reg;
        if (cmd.clear)
        begin
            stamp_we    = 1'b1;
            stamp_waddr = clr_reg;
            stamp_wdata = '0;
            fav_we      = 1'b1;
            fav_waddr   = clr_reg;
            fav_wdata   = 1'b0;
        end
        else if (cmd.exec && in_range)
        begin
            stamp_we = (action_reg == ACT_MARK);
            fav_we   = (action_reg == ACT_TOGGLE);
        end
    end

    always_ff @(posedge clk)
    begin
        if (stamp_we)
        begin
            stamp_mem[stamp_waddr] <= stamp_wdata;
        end
        if (fav_we)
        begin
            fav_mem[fav_waddr] <= fav_wdata;
        end
        rd_stamp_reg <= stamp_mem[scan_reg[IDX_W-1:0]];
        fav_rd_reg   <= fav_mem[fav_raddr];
    end

    always_comb
    begin
        out_load      = 1'b0;
        out_data_next = {1'b0, 1'b0, 6'(pend_idx_reg)};
        out_user_next = 2'b01;
        out_last_next = 1'b0;
        if (cmd.exec)
        begin
            out_load      = 1'b1;
            out_data_next = {1'b0,
                             (action_reg == ACT_TOGGLE) && in_range && !fav_rd_reg,
                             idx_reg};
            out_user_next = {((action_reg == ACT_MARK) || (action_reg == ACT_TOGGLE))
                             && !in_range, 1'b0};
            out_last_next = 1'b1;
        end
        else if (cmd.take && has_pend_reg)
        begin
            out_load = 1'b1;
        end
        else if (cmd.final_out)
        begin
            out_load      = 1'b1;
            out_last_next = 1'b1;
            if (!has_pend_reg)
            begin
                out_data_next = '0;
                out_user_next = 2'b00;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            action_reg <= action_t'(in_data[1:0]);
            idx_reg    <= in_data[7:2];
        end
        if (out_load)
        begin
            out_data_reg <= out_data_next;
            out_user_reg <= out_user_next;
            out_last_reg <= out_last_next;
        end
        rd_idx_reg  <= scan_reg[IDX_W-1:0];
        q_stamp_reg <= rd_stamp_reg;
        q_idx_reg   <= rd_idx_reg;
        if (q_vld_reg && (!best_found_reg || (q_stamp_reg > best_stamp_reg)))
        begin
            best_stamp_reg <= q_stamp_reg;
            best_idx_reg   <= q_idx_reg;
        end
        if (cmd.take)
        begin
            pend_idx_reg   <= best_idx_reg;
            prev_stamp_reg <= best_stamp_reg;
            prev_idx_reg   <= best_idx_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_count_reg  <= ITEM_COUNT_RESET;
            list_limit_reg  <= LIST_LIMIT_RESET;
            seq_reg         <= '0;
            clr_reg         <= '0;
            scan_active_reg <= 1'b0;
            scan_reg        <= '0;
            rd_vld_reg      <= 1'b0;
            q_vld_reg       <= 1'b0;
            best_found_reg  <= 1'b0;
            prev_vld_reg    <= 1'b0;
            has_pend_reg    <= 1'b0;
            cnt_reg         <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_addr)
                    CFG_ITEM_COUNT: item_count_reg <= cfg_data;
                    CFG_LIST_LIMIT: list_limit_reg <= cfg_data;
                    default:        item_count_reg <= item_count_reg;
                endcase
            end
            if (cmd.clear)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (cmd.exec && in_range && (action_reg == ACT_MARK))
            begin
                seq_reg <= seq_next;
            end
            rd_vld_reg <= issue;
            q_vld_reg  <= rd_vld_reg && qual;
            if (cmd.pass_start)
            begin
                scan_active_reg <= 1'b1;
                scan_reg        <= '0;
                best_found_reg  <= 1'b0;
            end
            else
            begin
                if (cmd.capture)
                begin
                    scan_active_reg <= 1'b0;
                end
                else if (issue)
                begin
                    scan_reg <= scan_reg + 1'b1;
                end
                if (q_vld_reg)
                begin
                    best_found_reg <= 1'b1;
                end
            end
            if (cmd.capture)
            begin
                has_pend_reg <= 1'b0;
                prev_vld_reg <= 1'b0;
                cnt_reg      <= '0;
            end
            else if (cmd.take)
            begin
                has_pend_reg <= 1'b1;
                prev_vld_reg <= 1'b1;
                cnt_reg      <= cnt_reg + 1'b1;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign status.clear_done = (clr_reg == IDX_W'(TABLE_ENTRIES - 1));
    assign status.out_free   = !out_valid_reg || out_ready;
    assign status.pass_done  = scan_active_reg && !issue && !rd_vld_reg && !q_vld_reg;
    assign status.best_found = best_found_reg;
    assign status.has_pend   = has_pend_reg;
    assign status.cap_hit    = ((cnt_reg + 1'b1) == cap);
    assign status.cap_zero   = (cap == '0);

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_user  = out_user_reg;
    assign out_last  = out_last_reg;

`ifndef SYNTHESIS
    a_pend_counted: assert property (@(posedge clk) disable iff (!rst_n)
        has_pend_reg |-> (cnt_reg != '0))
        else $error("Pending list entry without a count.");

    a_count_capped: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= 7'(CAP_MAX))
        else $error("List count exceeds its cap.");

    a_mark_steps: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.exec && in_range && (action_reg == ACT_MARK)) |=>
            (seq_reg == $past(seq_next)))
        else $error("Mark did not advance the sequence counter.");

    a_no_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |-> !out_load)
        else $error("Result overwritten while stalled.");
`endif

endmodule

>>> design/recency_table_top_k_ranker.sv
`timescale 1ns / 1ps
// Channel  | Signals                         | Beat contents (low bit first)
// s_axis   | tvalid tready tdata[7:0]        | action[1:0], item_index[7:2]
// m_axis   | tvalid tready tdata tuser tlast | see port comments; tlast is last
// cfg      | cfg_we cfg_addr cfg_data[6:0]   | 0 item_count, 1 list_limit
//
// After reset a clearing sweep zeroes every table entry before s_axis_tready rises.
// Mark, toggle and unused actions are captured, then executed once m_axis is free.
// A list runs one selection pass per emitted index over the entries in use, each
// reading them in turn on the single stamp read port, and one last pass that
// finds nothing unless list_limit is reached first.
// A stalled m_axis holds the pending result and halts the sequencer.

module recency_table_top_k_ranker
#(
    parameter int TABLE_ENTRIES = 64,
    parameter int STAMP_BITS    = 64
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // action[1:0], item_index[7:2]
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // entry_index[5:0], favorite_now[6], zero[7]
    output logic [1:0] m_axis_tuser,   // list_valid[0], index_error[1]
    output logic       m_axis_tlast,
    input  logic       cfg_we,
    input  logic       cfg_addr,
    input  logic [6:0] cfg_data
);
    import rtkr_pkg::*;

    rtkr_cmd_t    cmd;
    rtkr_status_t status;

    rtkr_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_action (action_t'(s_axis_tdata[1:0])),
        .status    (status),
        .in_ready  (s_axis_tready),
        .cmd       (cmd)
    );

    rtkr_datapath
    #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .STAMP_BITS    (STAMP_BITS)
    )
    u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data),
        .in_data   (s_axis_tdata),
        .out_ready (m_axis_tready),
        .cmd       (cmd),
        .out_valid (m_axis_tvalid),
        .out_data  (m_axis_tdata),
        .out_user  (m_axis_tuser),
        .out_last  (m_axis_tlast),
        .status    (status)
    );

endmodule
